// ===== sv/iqm_pkg.sv =====
// iqm_pkg: payload types and fixed constants for the I/Q byte magnitude block.
// No dependencies; used by iq_byte_magnitude and by whoever binds its channels.
`default_nettype none

package iqm_pkg;

  // One input request: unsigned I/Q bytes and end-of-buffer flag
  typedef struct packed {
    logic [7:0] i_byte;
    logic [7:0] q_byte;
    logic       last_in;
  } sample_t;

  // One result: Q16 magnitude and copied flag
  typedef struct packed {
    logic [15:0] magnitude;
    logic        last_out;
  } mag_t;

  // DC bias after reset: 127.4 * 256 rounded toward zero
  localparam logic [15:0] DC_OFFSET_RESET = 16'd32614;

  localparam int unsigned Q15_W  = 16;             // signed I and Q
  localparam int unsigned SQ_W   = 31;             // one square, at most 2^30
  localparam int unsigned ACC_W  = 32;             // Q30 sum, at most 2^31
  localparam int unsigned RAD_W  = ACC_W + 2;      // 4 * sum fed to the root
  localparam int unsigned ROOT_W = RAD_W / 2;      // root bits, one per stage
  localparam int unsigned REM_W  = ROOT_W + 2;     // partial remainder <= 2*root
  localparam int unsigned TRY_W  = REM_W + 2;      // remainder with next digit pair

endpackage

`default_nettype wire

// ===== sv/iqm_stream_if.sv =====
// iqm_stream_if: valid/ready channel with a payload of type T.
// No dependencies; carries iqm_pkg payload types or a plain register word.
`default_nettype none

interface iqm_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/iq_byte_magnitude.sv =====
// iq_byte_magnitude: streaming magnitude of unsigned 8-bit I/Q pairs.
// Depends on iqm_pkg (types, constants) and iqm_stream_if (channels).
//
//   channel  | dir | payload                          | request taken when
//   ---------+-----+----------------------------------+----------------------
//   samples  | in  | iqm_pkg::sample_t                | valid && ready
//   mags     | out | iqm_pkg::mag_t                   | valid && ready
//   cfg      | in  | dc_offset, 16 bit                | valid && ready (always)
//
// One request per clock while mags keeps up. Each request passes bias subtract,
// squaring, sum, then one root bit per stage through 17 stages, then the
// output register. The whole pipe advances together; a two-entry output
// (register plus skid) absorbs one request when mags stalls, after which
// samples.ready drops until the skid drains. Synchronous reset clears all
// valid bits and reloads dc_offset; payload registers are not reset.
`default_nettype none

module iq_byte_magnitude (
  input  wire logic   clk,
  input  wire logic   rst,
  iqm_stream_if.sink   samples,
  iqm_stream_if.source mags,
  iqm_stream_if.sink   cfg
);

  localparam int unsigned NSTG = iqm_pkg::ROOT_W;

  // ---------------------------------------------------------------------
  // Config register
  // ---------------------------------------------------------------------
  logic [15:0] dc_offset;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dc_offset <= iqm_pkg::DC_OFFSET_RESET;
    end else if (cfg.valid) begin
      dc_offset <= cfg.data;
    end
  end

  // Pipe advances whenever the skid is empty
  logic skid_vld;
  logic pipe_en;

  assign pipe_en       = !skid_vld;
  assign samples.ready = pipe_en;

  // ---------------------------------------------------------------------
  // Stage 1: remove DC bias, wraps mod 2^16, read as Q15
  // ---------------------------------------------------------------------
  logic                                   vld1;
  logic                                   last1;
  logic signed [iqm_pkg::Q15_W-1:0]       iv1;
  logic signed [iqm_pkg::Q15_W-1:0]       qv1;
  iqm_pkg::sample_t                       smp;

  assign smp = samples.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (pipe_en) begin
      vld1 <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      last1 <= smp.last_in;
      iv1   <= $signed({smp.i_byte, 8'h00} - dc_offset);
      qv1   <= $signed({smp.q_byte, 8'h00} - dc_offset);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: squares (16x16 signed, always non-negative)
  // ---------------------------------------------------------------------
  logic                        vld2;
  logic                        last2;
  logic [iqm_pkg::SQ_W-1:0]    isq2;
  logic [iqm_pkg::SQ_W-1:0]    qsq2;
  logic signed [31:0]          iprod;
  logic signed [31:0]          qprod;

  assign iprod = iv1 * iv1;
  assign qprod = qv1 * qv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else if (pipe_en) begin
      vld2 <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      last2 <= last1;
      isq2  <= iprod[iqm_pkg::SQ_W-1:0];
      qsq2  <= qprod[iqm_pkg::SQ_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: Q30 sum of squares
  // ---------------------------------------------------------------------
  logic                        vld3;
  logic                        last3;
  logic [iqm_pkg::ACC_W-1:0]   sum3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
    end else if (pipe_en) begin
      vld3 <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      last3 <= last2;
      sum3  <= {1'b0, isq2} + {1'b0, qsq2};
    end
  end

  // ---------------------------------------------------------------------
  // Square root of 4*sum, one result bit per stage (restoring method)
  // ---------------------------------------------------------------------
  logic                         sq_vld  [NSTG];
  logic                         sq_last [NSTG];
  logic [iqm_pkg::RAD_W-1:0]    sq_rad  [NSTG];
  logic [iqm_pkg::REM_W-1:0]    sq_rem  [NSTG];
  logic [iqm_pkg::ROOT_W-1:0]   sq_root [NSTG];

  for (genvar k = 0; k < NSTG; k++) begin : g_root
    logic                        v_in;
    logic                        l_in;
    logic [iqm_pkg::RAD_W-1:0]   rad_in;
    logic [iqm_pkg::REM_W-1:0]   rem_in;
    logic [iqm_pkg::ROOT_W-1:0]  root_in;
    logic [iqm_pkg::TRY_W-1:0]   part;
    logic [iqm_pkg::TRY_W-1:0]   trial;
    logic [iqm_pkg::TRY_W-1:0]   diff;
    logic                        take;

    if (k == 0) begin : g_first
      assign v_in    = vld3;
      assign l_in    = last3;
      assign rad_in  = {sum3, 2'b00};
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = sq_vld[k-1];
      assign l_in    = sq_last[k-1];
      assign rad_in  = sq_rad[k-1];
      assign rem_in  = sq_rem[k-1];
      assign root_in = sq_root[k-1];
    end

    // bring down the next digit pair and try root*4+1
    assign part  = {rem_in, rad_in[iqm_pkg::RAD_W-1 -: 2]};
    assign trial = {{(iqm_pkg::TRY_W-iqm_pkg::ROOT_W-2){1'b0}}, root_in, 2'b01};
    assign diff  = part - trial;
    assign take  = (part >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[k] <= 1'b0;
      end else if (pipe_en) begin
        sq_vld[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        sq_last[k] <= l_in;
        sq_rad[k]  <= {rad_in[iqm_pkg::RAD_W-3:0], 2'b00};
        sq_rem[k]  <= take ? diff[iqm_pkg::REM_W-1:0] : part[iqm_pkg::REM_W-1:0];
        sq_root[k] <= {root_in[iqm_pkg::ROOT_W-2:0], take};
      end
    end
  end

  // ---------------------------------------------------------------------
  // Saturate and hand off through output register plus skid
  // ---------------------------------------------------------------------
  iqm_pkg::mag_t res;
  iqm_pkg::mag_t out_data;
  iqm_pkg::mag_t skid_data;
  logic          out_vld;
  logic          arrive;

  assign res.magnitude = sq_root[NSTG-1][iqm_pkg::ROOT_W-1] ? 16'hFFFF
                                                            : sq_root[NSTG-1][15:0];
  assign res.last_out  = sq_last[NSTG-1];
  assign arrive        = pipe_en && sq_vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else if (!out_vld || mags.ready) begin
      if (skid_vld) begin
        out_vld  <= 1'b1;
        skid_vld <= 1'b0;
      end else begin
        out_vld  <= arrive;
      end
    end else if (arrive) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld || mags.ready) begin
      out_data <= skid_vld ? skid_data : res;
    end
    if (out_vld && !mags.ready && arrive) begin
      skid_data <= res;
    end
  end

  assign mags.valid = out_vld;
  assign mags.data  = out_data;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_vld |-> out_vld)
    else $error("skid holds a result while output register is empty");

  a_skid_catches: assert property (@(posedge clk) disable iff (rst)
    out_vld && !mags.ready && arrive |=> skid_vld)
    else $error("result leaving the pipe was not caught by the skid");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    skid_vld |=> $stable(sq_root[NSTG-1]) && $stable(sq_vld[NSTG-1]))
    else $error("pipe moved while stalled");

endmodule

`default_nettype wire
